### design/length_prefixed_frame_deframer_unit_assert.svh
// assertion macros for the length-prefixed frame deframer
// clocked on clk and disabled while rst_n is low; bodies are empty in synthesis
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LPFD_ASSERT_HOLDS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");
`define LPFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence missing");
`else
`define LPFD_ASSERT_HOLDS(name, expr)
`define LPFD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### design/lpfd_pkg.sv
// shared types and constants of the length-prefixed frame deframer
// no dependencies
`default_nettype none

package lpfd_pkg;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned COUNT_BITS = 16;

    localparam logic [BYTE_BITS-1:0]  SYNC_FIRST        = 8'h23;  // '#'
    localparam logic [BYTE_BITS-1:0]  SYNC_SECOND       = 8'h21;  // '!'
    localparam logic [COUNT_BITS-1:0] MAX_PAYLOAD_RESET = 16'd500;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  payload_byte;
        logic [COUNT_BITS-1:0] byte_index;
        logic                  frame_last;
        logic                  frame_abort;
    } result_t;

    // parser to output register
    typedef struct packed {
        logic    load;
        result_t res;
    } handoff_t;

endpackage

`default_nettype wire

### design/lpfd_in_stage.sv
// input register stage of the deframer: holds one received byte
// depends on lpfd_pkg
`default_nettype none

module lpfd_in_stage
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lpfd_pkg::BYTE_BITS-1:0] s_data,
    input  wire logic                          consume,
    output logic                               in_valid,
    output logic [lpfd_pkg::BYTE_BITS-1:0]     in_byte
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [lpfd_pkg::BYTE_BITS-1:0] byte_reg;

    // empty or draining this cycle
    assign s_ready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_data;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

### design/lpfd_parser.sv
// sync hunt, length read and payload count of the deframer
// depends on lpfd_pkg
`default_nettype none

module lpfd_parser
#(
    parameter int unsigned LENGTH_BITS = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [lpfd_pkg::BYTE_BITS-1:0] in_byte,
    input  wire logic [lpfd_pkg::COUNT_BITS-1:0] max_payload,
    input  wire logic                           out_free,
    output logic                                consume,
    output lpfd_pkg::handoff_t                  handoff
);

    lpfd_pkg::phase_t                phase_reg, phase_next;
    logic                            sync_reg, sync_next;
    logic                            high_reg, high_next;
    logic [LENGTH_BITS-1:0]          decl_reg, decl_next;
    logic [lpfd_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic [lpfd_pkg::COUNT_BITS-1:0] cnt_inc;
    logic [lpfd_pkg::COUNT_BITS-1:0] decl_wide;
    logic [lpfd_pkg::COUNT_BITS-1:0] byte_wide;
    logic [lpfd_pkg::COUNT_BITS-1:0] byte_high;
    logic                            in_payload;
    logic                            hit_last;
    logic                            hit_limit;

    always_comb
    begin
        decl_wide = '0;
        decl_wide[LENGTH_BITS-1:0] = decl_reg;
    end

    assign byte_wide  = {{(lpfd_pkg::COUNT_BITS - lpfd_pkg::BYTE_BITS){1'b0}}, in_byte};
    assign byte_high  = {in_byte, {(lpfd_pkg::COUNT_BITS - lpfd_pkg::BYTE_BITS){1'b0}}};
    assign cnt_inc    = cnt_reg + 1'b1;
    assign hit_last   = (cnt_inc == decl_wide);
    assign hit_limit  = (cnt_inc >= max_payload);
    assign in_payload = (phase_reg == lpfd_pkg::PH_PAYLOAD);

    // payload bytes need room in the output register
    assign consume = in_valid && (!in_payload || out_free);

    always_comb
    begin
        handoff.load             = consume && in_payload;
        handoff.res.payload_byte = in_byte;
        handoff.res.byte_index   = cnt_reg;
        handoff.res.frame_last   = hit_last;
        handoff.res.frame_abort  = !hit_last && hit_limit;
    end

    always_comb
    begin
        phase_next = phase_reg;
        sync_next  = sync_reg;
        high_next  = high_reg;
        decl_next  = decl_reg;
        cnt_next   = cnt_reg;
        case (phase_reg)
            lpfd_pkg::PH_LENGTH:
            begin
                if (!high_reg)
                begin
                    decl_next = byte_high[LENGTH_BITS-1:0];
                    high_next = 1'b1;
                end
                else
                begin
                    decl_next  = decl_reg | byte_wide[LENGTH_BITS-1:0];
                    cnt_next   = '0;
                    phase_next = lpfd_pkg::PH_PAYLOAD;
                end
            end
            lpfd_pkg::PH_PAYLOAD:
            begin
                cnt_next = cnt_inc;
                if (hit_last || hit_limit)
                begin
                    // frame done or dropped: back to the hunt
                    phase_next = lpfd_pkg::PH_HUNT;
                    sync_next  = 1'b0;
                    high_next  = 1'b0;
                    decl_next  = '0;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                phase_next = lpfd_pkg::PH_HUNT;
                if (in_byte == lpfd_pkg::SYNC_FIRST)
                begin
                    sync_next = 1'b1;
                end
                else if (sync_reg)
                begin
                    sync_next = 1'b0;
                    if (in_byte == lpfd_pkg::SYNC_SECOND)
                    begin
                        high_next  = 1'b0;
                        decl_next  = '0;
                        phase_next = lpfd_pkg::PH_LENGTH;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lpfd_pkg::PH_HUNT;
            sync_reg  <= 1'b0;
            high_reg  <= 1'b0;
            decl_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            sync_reg  <= sync_next;
            high_reg  <= high_next;
            decl_reg  <= decl_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### design/lpfd_out_stage.sv
// result register of the deframer, drives the master stream side
// depends on lpfd_pkg
`default_nettype none

module lpfd_out_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lpfd_pkg::handoff_t handoff,
    output logic                    out_free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lpfd_pkg::result_t       m_res
);

    logic              valid_reg;
    logic              valid_next;
    lpfd_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (handoff.load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff.load)
        begin
            res_reg <= handoff.res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

### design/length_prefixed_frame_deframer_unit.sv
// top level of the length-prefixed frame deframer
// depends on lpfd_pkg, lpfd_in_stage, lpfd_parser, lpfd_out_stage and the assert header
//
// usage:
//   s_axis carries one received serial byte per transaction (tdata[7:0]).
//   the parser hunts for the sync pair '#' '!', reads a 16-bit big-endian
//   length, then forwards each payload byte on m_axis with its index.
//   m_axis tlast marks the byte that completes the declared length; tuser
//   marks a byte at which the frame hit max_payload_bytes unfinished and
//   was dropped (the parser goes back to hunting). header bytes and bytes
//   outside a frame produce no transaction.
//   a payload byte reaches m_axis through the input register, then the
//   result register.
//   throughput: one byte per cycle while m_axis does not stall; the parser
//   updates combinationally between the two registers.
//   a stalled m_axis holds its result; the input register keeps taking
//   header bytes, and a payload byte waits in the input register until the
//   result register frees up, so s_axis tready drops only then.
//   reset: parser returns to hunting, both registers empty, limit = 500.
//   cfg_wr_en/cfg_wr_data write max_payload_bytes; write only when idle.
`default_nettype none

`include "length_prefixed_frame_deframer_unit_assert.svh"

module length_prefixed_frame_deframer_unit
#(
    parameter int unsigned LENGTH_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // receive side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // payload side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] payload_byte, [23:8] byte_index
    output logic             m_axis_tlast,   // frame_last
    output logic             m_axis_tuser,   // [0] frame_abort
    // limit register
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    logic [lpfd_pkg::COUNT_BITS-1:0] max_payload_reg;

    logic                           in_valid;
    logic [lpfd_pkg::BYTE_BITS-1:0] in_byte;
    logic                           consume;
    logic                           out_free;
    lpfd_pkg::handoff_t             handoff;
    lpfd_pkg::result_t              m_res;

    // limit at which an unfinished frame is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= lpfd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    lpfd_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_data   (s_axis_tdata),
        .consume  (consume),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    lpfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .max_payload (max_payload_reg),
        .out_free    (out_free),
        .consume     (consume),
        .handoff     (handoff)
    );

    lpfd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .handoff  (handoff),
        .out_free (out_free),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (m_res)
    );

    // pack result fields onto the stream
    assign m_axis_tdata = {m_res.byte_index, m_res.payload_byte};
    assign m_axis_tlast = m_res.frame_last;
    assign m_axis_tuser = m_res.frame_abort;

    // a result is only loaded when the output register can take it
    `LPFD_ASSERT_HOLDS(a_load_into_free, !handoff.load || !m_axis_tvalid || m_axis_tready)
    // a byte that is not consumed stays in the input register unchanged
    `LPFD_ASSERT_NEXT(a_input_held, in_valid && !consume, in_valid && $stable(in_byte))
    // completion and drop never mark the same byte
    `LPFD_ASSERT_HOLDS(a_last_abort_excl, !m_axis_tvalid || !(m_axis_tlast && m_axis_tuser))
    // the limit always cuts a frame before the index counter wraps
    `LPFD_ASSERT_HOLDS(a_index_bound, !m_axis_tvalid || (m_axis_tdata[23:8] != 16'hFFFF))

endmodule

`default_nettype wire
